// ----- rtl/pipw_pkg.sv -----
// Shared constants and types for the winding-number point-in-polygon block.
// No dependencies; imported by pipw_ctrl, pipw_dpath and the top level.
package pipw_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int CNT_W       = 7;   // vertex_count and vertex_index width
  localparam int COORD_W     = 32;  // signed Q16.16 coordinate
  localparam int WIND_W      = 8;   // winding number, modulo 2^8
  localparam int IN_TDATA_W  = 72;  // 7 + 32 + 32, padded to bytes
  localparam int OUT_TDATA_W = 16;  // 1 + 8, padded to bytes

  // Cycles after the last store read until the winding sum is final:
  // diff stage, product stage, accumulate.
  localparam int DRAIN_LEN = 3;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic wr_en;     // vertex beat: write the store
    logic capture;   // query beat: latch point, clear sum
    logic rd_en;     // read one store entry
    logic rd_first;  // entry 0: no edge ends here
    logic cnt_zero;  // empty polygon
    logic load_out;  // move sum into output register
  } ctl_cmd_t;

endpackage

// ----- rtl/point_in_polygon_winding_top.sv -----
// Winding-number point-in-polygon test. A vertex beat (tuser 0) writes one
// polygon corner into the vertex store and keeps the block ready for the next
// beat; store vertex_count+1 corners with the last equal to the first. A query
// beat (tuser 1) walks the edges by reading its count+1 store entries one per
// cycle, then drains the side-test pipeline and loads the result once the
// output is free, holding off new beats; a zero count skips reads and drain.
// The next beat is taken while a finished result still waits at the output.
// The store is not cleared at reset; query only polygons that were written.
// Depends on pipw_pkg, pipw_ctrl and pipw_dpath.
module point_in_polygon_winding_top #(
  parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [6:0] vertex_index, [38:7] x_coord, [70:39] y_coord, [71] zero
  input  logic [pipw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] inside_res, [8:1] winding, [15:9] zero
  output logic [pipw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pipw_pkg::CNT_W-1:0]       cfg_data
);
  import pipw_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES + 1);

  ctl_cmd_t                  cmd;
  logic [IW-1:0]             rd_addr;
  logic                      inside_res;
  logic signed [WIND_W-1:0]  winding;

  pipw_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .IW          (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  pipw_dpath #(
    .MAX_VERTICES(MAX_VERTICES),
    .IW          (IW)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .vertex_index(in_tdata[CNT_W-1:0]),
    .x_coord     ($signed(in_tdata[CNT_W+COORD_W-1:CNT_W])),
    .y_coord     ($signed(in_tdata[CNT_W+2*COORD_W-1:CNT_W+COORD_W])),
    .inside_res  (inside_res),
    .winding     (winding)
  );

  assign out_tdata = {{(OUT_TDATA_W - WIND_W - 1){1'b0}}, winding, inside_res};

endmodule

// ----- rtl/pipw_dpath.sv -----
// Datapath: vertex store, edge side-test pipeline and winding accumulator.
// Depends on pipw_pkg; driven by commands from pipw_ctrl.
module pipw_dpath #(
  parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
  parameter int IW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pipw_pkg::ctl_cmd_t                  cmd,
  input  logic [IW-1:0]                       rd_addr,
  input  logic [pipw_pkg::CNT_W-1:0]          vertex_index,
  input  logic signed [pipw_pkg::COORD_W-1:0] x_coord,
  input  logic signed [pipw_pkg::COORD_W-1:0] y_coord,
  output logic                                inside_res,
  output logic signed [pipw_pkg::WIND_W-1:0]  winding
);
  import pipw_pkg::*;

  localparam int DEPTH = MAX_VERTICES + 1;
  localparam int CW    = (IW > CNT_W) ? IW : CNT_W;
  localparam int DW    = COORD_W + 1;      // coordinate difference
  localparam int PW    = 2 * DW;           // exact product
  localparam int SW    = PW + 1;           // difference of products

  logic [2*COORD_W-1:0] mem [DEPTH];       // x upper half, y lower half
  logic [2*COORD_W-1:0] rdata_r, prev_r;
  logic                 rd_vld_r, rd_first_r;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic [CW-1:0]             idx_w;

  logic signed [COORD_W-1:0] x0, y0, x1, y1;
  logic signed [DW-1:0]      d1_nxt, d2_nxt, d3_nxt, d4_nxt;
  logic signed [DW-1:0]      d1_r, d2_r, d3_r, d4_r;
  logic                      s1_vld_r, up1_r, dn1_r;
  logic signed [PW-1:0]      p1_nxt, p2_nxt, p1_r, p2_r;
  logic                      s2_vld_r, up2_r, dn2_r;
  logic signed [SW-1:0]      diff;
  logic                      side_neg, side_pos;
  logic signed [WIND_W-1:0]  wn_r, wn_nxt;
  logic                      inside_r;
  logic signed [WIND_W-1:0]  wind_r;

  assign idx_w = CW'(vertex_index);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (idx_w < CW'(DEPTH))) begin
      mem[idx_w[IW-1:0]] <= {x_coord, y_coord};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      rd_first_r <= cmd.rd_first;
      s1_vld_r   <= rd_vld_r & ~rd_first_r;
      s2_vld_r   <= s1_vld_r;
    end
  end

  // edge runs from prev_r (entry n) to rdata_r (entry n+1)
  assign x0 = $signed(prev_r[2*COORD_W-1:COORD_W]);
  assign y0 = $signed(prev_r[COORD_W-1:0]);
  assign x1 = $signed(rdata_r[2*COORD_W-1:COORD_W]);
  assign y1 = $signed(rdata_r[COORD_W-1:0]);

  assign d1_nxt = $signed({x1[COORD_W-1], x1}) - $signed({x0[COORD_W-1], x0});
  assign d2_nxt = $signed({py_r[COORD_W-1], py_r}) - $signed({y0[COORD_W-1], y0});
  assign d3_nxt = $signed({px_r[COORD_W-1], px_r}) - $signed({x0[COORD_W-1], x0});
  assign d4_nxt = $signed({y1[COORD_W-1], y1}) - $signed({y0[COORD_W-1], y0});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= x_coord;
      py_r <= y_coord;
    end
    if (rd_vld_r) begin
      prev_r <= rdata_r;
    end
    d1_r  <= d1_nxt;
    d2_r  <= d2_nxt;
    d3_r  <= d3_nxt;
    d4_r  <= d4_nxt;
    up1_r <= (y0 <= py_r) && (y1 > py_r);
    dn1_r <= (y0 > py_r) && (y1 <= py_r);
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    up2_r <= up1_r;
    dn2_r <= dn1_r;
  end

  assign p1_nxt = d1_r * d2_r;
  assign p2_nxt = d3_r * d4_r;

  assign diff     = $signed({p1_r[PW-1], p1_r}) - $signed({p2_r[PW-1], p2_r});
  assign side_neg = diff[SW-1];
  assign side_pos = ~diff[SW-1] & (diff != '0);

  always_comb begin
    wn_nxt = wn_r;
    if (s2_vld_r && up2_r && side_pos) begin
      wn_nxt = wn_r + WIND_W'(1);
    end else if (s2_vld_r && dn2_r && side_neg) begin
      wn_nxt = wn_r - WIND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wn_r <= '0;
    end else begin
      wn_r <= wn_nxt;
    end
    if (cmd.load_out) begin
      inside_r <= cmd.cnt_zero | (wn_r != '0);
      wind_r   <= wn_r;
    end
  end

  assign inside_res = inside_r;
  assign winding    = wind_r;

endmodule

// ----- rtl/pipw_ctrl.sv -----
// Controller: handshakes, edge walk sequencing and output register valid.
// Depends on pipw_pkg; issues ctl_cmd_t to pipw_dpath.
module pipw_ctrl #(
  parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
  parameter int IW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_kind,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pipw_pkg::CNT_W-1:0] cfg_data,
  output pipw_pkg::ctl_cmd_t         cmd,
  output logic [IW-1:0]              rd_addr
);
  import pipw_pkg::*;

  localparam int CW = (IW > CNT_W) ? IW : CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [IW-1:0]  addr_r, addr_nxt;
  logic [1:0]     drain_r, drain_nxt;
  logic [CNT_W-1:0] vcount_r;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  vcount_w;
  logic [IW-1:0]  count_eff;
  logic           in_beat;

  assign vcount_w  = CW'(vcount_r);
  assign count_eff = (vcount_w > CW'(MAX_VERTICES)) ? IW'(MAX_VERTICES) : vcount_w[IW-1:0];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign rd_addr    = addr_r;

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    drain_nxt    = drain_r;
    cmd          = '0;
    cmd.cnt_zero = (vcount_r == '0);
    cmd.wr_en    = in_beat && (in_kind == KIND_VERTEX);
    cmd.capture  = in_beat && (in_kind == KIND_QUERY);
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (cmd.capture) begin
          state_nxt = cmd.cnt_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        // entries 0..count, one read a cycle
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (addr_r == '0);
        if (addr_r == count_eff) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == 2'(DRAIN_LEN - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      drain_r     <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_addr <= count_eff))
    else $error("store read beyond polygon end");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("output register overwritten before taken");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.rd_en)
    else $error("store read while accepting beats");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without finished query");

endmodule

// ----- verif/point_in_polygon_winding_top_tb.sv -----
// Self-checking bench for point_in_polygon_winding_top: vertex loads, count writes and point
// queries, with results checked against an in-bench winding-number predictor or the directed rows' expected values.
// Depends on pipw_pkg and the RTL of point_in_polygon_winding_top.
`timescale 1ns / 100ps

module point_in_polygon_winding_top_tb;
  import pipw_pkg::*;

  localparam int     MAXV         = MAX_VERTICES_DEF;
  localparam int     DRAIN_CYCLES = MAXV + 16;   // a full query walk plus pipeline
  localparam int     RANDOM_ITEMS = 1300;
  localparam longint LIMIT_CYCLES = 3_000_000;

  typedef struct packed {
    logic       in_poly;
    logic [7:0] wind;
  } wind_result_t;

  typedef enum logic [1:0] {ROW_VERTEX, ROW_QUERY, ROW_COUNT} row_op_t;

  // For ROW_COUNT rows idx carries the vertex_count value.
  typedef struct packed {
    row_op_t      op;
    logic [6:0]   idx;
    logic [31:0]  x;
    logic [31:0]  y;
    logic         typed;
    wind_result_t want;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data   = '0;

  point_in_polygon_winding_top #(.MAX_VERTICES(MAXV)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [31:0] vtx_x [0:MAXV];
  logic signed [31:0] vtx_y [0:MAXV];
  logic [CNT_W-1:0]   count_reg = '0;
  wind_result_t       wind_expect_q [$];

  int err_cnt = 0, result_cnt = 0, inside_cnt = 0, items_in = 0;
  int wind_lo = 0, wind_hi = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  dir_row_t dir_rows [27] = '{
    // empty polygon straight after reset: everything is inside
    '{ROW_QUERY,  7'd0,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b1, 8'h00}},
    '{ROW_QUERY,  7'd0,   32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b1, 8'h00}},
    // full-range square, counterclockwise; exercises the widest products
    '{ROW_VERTEX, 7'd0,   32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_VERTEX, 7'd1,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ROW_VERTEX, 7'd2,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 7'd3,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 7'd4,   32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_COUNT,  7'd4,   32'h0,         32'h0,         1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h0,         32'h0,         1'b1, '{1'b1, 8'h01}},
    '{ROW_QUERY,  7'd0,   32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h7FFF_FFFF, 32'h0,         1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h8000_0000, 32'h0,         1'b0, '0},
    // small clockwise triangle: winding -1 inside
    '{ROW_VERTEX, 7'd0,   32'h0,         32'h0,         1'b0, '0},
    '{ROW_VERTEX, 7'd1,   32'h0,         32'h000A_0000, 1'b0, '0},
    '{ROW_VERTEX, 7'd2,   32'h000A_0000, 32'h0,         1'b0, '0},
    '{ROW_VERTEX, 7'd3,   32'h0,         32'h0,         1'b0, '0},
    '{ROW_COUNT,  7'd3,   32'h0,         32'h0,         1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h0002_0000, 32'h0002_0000, 1'b1, '{1'b1, 8'hFF}},
    '{ROW_QUERY,  7'd0,   32'h0006_0000, 32'h0006_0000, 1'b1, '{1'b0, 8'h00}},
    // slots past the store are dropped; top slot is legal
    '{ROW_VERTEX, 7'd65,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 7'd127, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_VERTEX, 7'd64,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h0002_0000, 32'h0002_0000, 1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h0005_0000, 32'h0005_0000, 1'b0, '0},
    '{ROW_COUNT,  7'd0,   32'h0,         32'h0,         1'b0, '0},
    '{ROW_QUERY,  7'd0,   32'h0,         32'h0,         1'b1, '{1'b1, 8'h00}}
  };

  // Winding number of the stored polygon around (px, py); side test kept exact at 66 bits.
  function automatic wind_result_t predict_winding(logic signed [31:0] px,
                                                   logic signed [31:0] py);
    int                 eff;
    int                 wn;
    logic signed [31:0] x0, y0, x1, y1;
    logic signed [65:0] side_val;
    wind_result_t       r;
    eff = (count_reg > MAXV) ? MAXV : count_reg;
    if (eff == 0) return '{1'b1, 8'h00};
    wn = 0;
    for (int n = 0; n < eff; n++) begin
      x0 = vtx_x[n];
      y0 = vtx_y[n];
      x1 = vtx_x[n + 1];
      y1 = vtx_y[n + 1];
      side_val = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
      if (y0 <= py) begin
        if (y1 > py && side_val > 0) wn++;
      end else if (y1 <= py && side_val < 0) begin
        wn--;
      end
    end
    r.in_poly = (wn != 0);
    r.wind    = wn[7:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int shift);
    return $signed($urandom) >>> shift;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d (result %0d, %0t)", what, got, want,
             result_cnt, $realtime);
    err_cnt++;
  endtask

  // Present one beat at the falling edge; predictor updated when it is taken.
  task automatic send_beat(input logic kind, input logic [6:0] idx, input logic [31:0] x,
                           input logic [31:0] y, input logic typed, input wind_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_VERTEX) begin
      if (idx <= MAXV) begin
        vtx_x[idx] = x;
        vtx_y[idx] = y;
        items_in++;
      end
    end else begin
      wind_expect_q.push_back(typed ? want : predict_winding(x, y));
      items_in++;
    end
    @(negedge clk);
  endtask

  // Count changes only with the block drained.
  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (wind_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    wind_result_t      want;
    logic signed [7:0] got_w;
    if (rst_n && out_tvalid && out_tready) begin
      got_w = out_tdata[8:1];
      result_cnt++;
      if (out_tdata[0]) inside_cnt++;
      if (got_w < wind_lo) wind_lo = got_w;
      if (got_w > wind_hi) wind_hi = got_w;
      if (wind_expect_q.size() == 0) begin
        report_mismatch("result beat with no query pending", out_tdata, 0);
      end else begin
        want = wind_expect_q.pop_front();
        if (out_tdata[0] !== want.in_poly)
          report_mismatch("inside_res", out_tdata[0], want.in_poly);
        if (out_tdata[8:1] !== want.wind)
          report_mismatch("winding", got_w, $signed(want.wind));
        if (out_tdata[15:9] !== '0)
          report_mismatch("tdata pad", out_tdata[15:9], 0);
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("TIMEOUT with %0d results pending", wind_expect_q.size());
    $display("point_in_polygon_winding_top verification failed");
    $finish;
  end

  initial begin
    int          goal, phase, mode, eff, shift, shape, half, n_items, sel, k;
    logic [6:0]  cnt;
    logic [31:0] px, py;
    for (int i = 0; i <= MAXV; i++) begin
      vtx_x[i] = '0;
      vtx_y[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_COUNT)
        set_vertex_count(dir_rows[i].idx);
      else
        send_beat(dir_rows[i].op == ROW_QUERY ? KIND_QUERY : KIND_VERTEX, dir_rows[i].idx,
                  dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
    end

    goal = items_in + RANDOM_ITEMS;
    for (phase = 0; items_in < goal; phase++) begin
      mode = (phase + phase / 8) % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      case (phase % 8)
        0: cnt = 7'(MAXV);
        1: cnt = 7'($urandom_range(3, 8));
        2: cnt = '0;
        3: cnt = 7'd127;                       // clamps to MAXV
        4: cnt = 7'($urandom_range(3, MAXV));
        5: cnt = 7'd1;
        6: cnt = 7'($urandom_range(MAXV + 1, 126));
        default: cnt = 7'($urandom_range(2, 16));
      endcase
      set_vertex_count(cnt);
      eff   = (cnt > MAXV) ? MAXV : cnt;
      shift = $urandom_range(0, 28);
      shape = $urandom_range(0, 9);
      // shape 0: open ring; 7..9 (even eff of 4 or more): loop traced twice for winding of two
      half  = (shape >= 7 && eff >= 4 && eff % 2 == 0) ? eff / 2 : eff;
      for (k = 0; k <= eff; k++) begin
        if (half == 0 || k < half || (k == eff && shape == 0))
          send_beat(KIND_VERTEX, k[6:0], rand_coord(shift), rand_coord(shift), 1'b0, '0);
        else
          send_beat(KIND_VERTEX, k[6:0], vtx_x[k % half], vtx_y[k % half], 1'b0, '0);
      end

      n_items = $urandom_range(30, 70);
      repeat (n_items) begin
        sel = $urandom_range(99);
        k   = $urandom_range(0, eff);
        if (sel < 8) begin
          send_beat(KIND_VERTEX, k[6:0], rand_coord(shift), rand_coord(shift), 1'b0, '0);
        end else if (sel < 12) begin
          send_beat(KIND_VERTEX, 7'($urandom_range(MAXV + 1, 127)), $urandom, $urandom,
                    1'b0, '0);
        end else begin
          sel = $urandom_range(99);
          if (sel < 55) begin
            px = rand_coord(shift);
            py = rand_coord(shift);
          end else if (sel < 70) begin
            px = vtx_x[k];
            py = vtx_y[k];
          end else if (sel < 85) begin
            px = rand_coord(shift);
            py = vtx_y[k];
          end else if (sel < 92) begin
            px = vtx_x[k];
            py = rand_coord(shift);
          end else begin
            px = $urandom;
            py = $urandom;
          end
          send_beat(KIND_QUERY, 7'($urandom), px, py, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (wind_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d beats over %0d count settings (0, 1, %0d, clamped and random).",
             items_in, phase, MAXV);
    $display("%0d query results, %0d inside, winding seen from %0d to %0d, %0d mismatches.",
             result_cnt, inside_cnt, wind_lo, wind_hi, err_cnt);
    if (err_cnt == 0)
      $display("point_in_polygon_winding_top verification clean");
    else
      $display("point_in_polygon_winding_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pipw_pkg.sv
rtl/pipw_dpath.sv
rtl/pipw_ctrl.sv
rtl/point_in_polygon_winding_top.sv
verif/point_in_polygon_winding_top_tb.sv
